FILE: sv/assert_macros.svh
// Assertion macros used by the conv2d 3x3 core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define C2D_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define C2D_ASSERT_NEVER(lbl, ck, rn, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
    else $error(msg);

`endif

FILE: sv/c2d_pkg.sv
// Types and constants shared by the conv2d 3x3 block.
`timescale 1ns / 1ps
package c2d_pkg;

  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_TAPS_LO  = 2'd2,
    REG_TAP_LAST = 2'd3
  } c2d_reg_t;

  localparam logic [10:0] WidthReset  = 11'd21;
  localparam logic [11:0] HeightReset = 12'd21;
  localparam logic [63:0] TapsReset   = 64'd2;
  localparam logic [7:0]  TapLastReset = 8'd0;
  localparam logic [11:0] MaxHeight   = 12'd4095;

  // Result queue; one entry per result word in flight.
  localparam int FifoDepth = 8;
  localparam int FifoAw    = 3;

  // 3x3 window or kernel, element k in bits 8k+7..8k (row-major).
  typedef logic [8:0][7:0] c2d_win_t;

  typedef struct packed {
    logic [9:0]  col;
    logic [11:0] row;
    logic        last;
  } c2d_meta_t;

  typedef struct packed {
    logic [7:0] pixel;
    c2d_meta_t  meta;
  } c2d_res_t;

endpackage

FILE: sv/conv2d_3x3_valid_u8_core.sv
// An accepted pixel's result word passes stage 1, stage 2, the MAC product and sum registers, then the queue.
// Throughput: one pixel per cycle while in_stall is low; the two line-store RAMs read a column in the
// accept cycle and write it back in the next cycle, one port each per cycle.
// The input stalls while 8 result words are owed, queued or still in the pipeline.
// Reset (rst_n low, synchronous) clears counters, window, pipeline and queue and
// restores register defaults; line-store contents are left as they are.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module conv2d_3x3_valid_u8_core import c2d_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel,
  output logic [9:0]  out_col,
  output logic [11:0] out_row,
  output logic        out_frame_last,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);

  // configuration
  logic [10:0] width_r;
  logic [11:0] height_r;
  logic [63:0] taps_lo_r;
  logic [7:0]  tap_last_r;
  logic [12:0] eff_w;
  logic [11:0] eff_h;

  // position counters
  logic [CW-1:0] col_r, col_nxt;
  logic [11:0]   row_r, row_nxt;
  logic          acc, row_end, frame_end, emit;
  c2d_meta_t     meta;

  // stage 1: RAM read data valid
  logic          s1_valid_r, s1_emit_r;
  logic [7:0]    s1_px_r;
  logic [CW-1:0] s1_col_r;
  c2d_meta_t     s1_meta_r;
  logic [7:0]    older_rd, newer_rd;

  // stage 2: window updated
  c2d_win_t  win_r, win_nxt;
  logic      s2_valid_r;
  c2d_meta_t s2_meta_r;

  logic       mac_valid;
  c2d_meta_t  mac_meta;
  logic [7:0] mac_pixel;

  // result queue
  c2d_res_t          fifo_r [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [FifoAw:0]   fifo_cnt_r, occ_r;
  logic              out_take;
  c2d_res_t          head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WidthReset;
      height_r   <= HeightReset;
      taps_lo_r  <= TapsReset;
      tap_last_r <= TapLastReset;
    end else if (cfg_wr_en) begin
      unique case (c2d_reg_t'(cfg_index))
        REG_WIDTH:    width_r    <= cfg_wdata[10:0];
        REG_HEIGHT:   height_r   <= cfg_wdata[11:0];
        REG_TAPS_LO:  taps_lo_r  <= cfg_wdata;
        REG_TAP_LAST: tap_last_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = 13'(width_r);
    if (eff_w < 13'd3) begin
      eff_w = 13'd3;
    end else if (eff_w > MaxW) begin
      eff_w = MaxW;
    end
    eff_h = (height_r < 12'd3) ? 12'd3 : height_r;
    if (eff_h > MaxHeight) begin
      eff_h = MaxHeight;
    end
  end

  assign acc       = in_valid && !in_stall;
  assign in_stall  = (occ_r == (FifoAw+1)'(FifoDepth));
  assign row_end   = (13'(col_r) + 13'd1) >= eff_w;
  assign frame_end = row_end && ((13'(row_r) + 13'd1) >= 13'(eff_h));
  assign emit      = (13'(col_r) >= 13'd2) && (row_r >= 12'd2);

  always_comb begin
    meta.col  = 10'(13'(col_r) - 13'd2);
    meta.row  = row_r - 12'd2;
    meta.last = frame_end;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? 12'd0 : row_r + 12'd1;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      win_r      <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= acc;
      s2_valid_r <= s1_valid_r && s1_emit_r;
      win_r      <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_emit_r <= emit;
    s1_px_r   <= in_pixel;
    s1_col_r  <= col_r;
    s1_meta_r <= meta;
    s2_meta_r <= s1_meta_r;
  end

  // Read the column at accept; write it back in the next cycle.
  c2d_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_older (
    .clk     (clk),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data (newer_rd),
    .rd_en   (acc),
    .rd_addr (col_r),
    .rd_data (older_rd)
  );

  c2d_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_newer (
    .clk     (clk),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data (s1_px_r),
    .rd_en   (acc),
    .rd_addr (col_r),
    .rd_data (newer_rd)
  );

  // Shift the window left and load the new column on the right.
  always_comb begin
    win_nxt = win_r;
    if (s1_valid_r) begin
      win_nxt[0] = win_r[1];
      win_nxt[1] = win_r[2];
      win_nxt[2] = older_rd;
      win_nxt[3] = win_r[4];
      win_nxt[4] = win_r[5];
      win_nxt[5] = newer_rd;
      win_nxt[6] = win_r[7];
      win_nxt[7] = win_r[8];
      win_nxt[8] = s1_px_r;
    end
  end

  c2d_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid_r),
    .in_meta   (s2_meta_r),
    .window    (win_r),
    .taps      ({tap_last_r, taps_lo_r}),
    .out_valid (mac_valid),
    .out_meta  (mac_meta),
    .out_pixel (mac_pixel)
  );

  // occ_r counts result words accepted but not yet delivered.
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      occ_r      <= '0;
    end else begin
      if (mac_valid) begin
        wr_ptr_r <= wr_ptr_r + FifoAw'(1);
      end
      if (out_take) begin
        rd_ptr_r <= rd_ptr_r + FifoAw'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + (FifoAw+1)'(mac_valid) - (FifoAw+1)'(out_take);
      occ_r      <= occ_r + (FifoAw+1)'(acc && emit) - (FifoAw+1)'(out_take);
    end
  end

  always_ff @(posedge clk) begin
    if (mac_valid) begin
      fifo_r[wr_ptr_r] <= '{pixel: mac_pixel, meta: mac_meta};
    end
  end

  assign head           = fifo_r[rd_ptr_r];
  assign out_valid      = (fifo_cnt_r != '0);
  assign out_pixel      = head.pixel;
  assign out_col        = head.meta.col;
  assign out_row        = head.meta.row;
  assign out_frame_last = head.meta.last;

  `C2D_ASSERT(a_no_ram_collide, clk, rst_n, (s1_valid_r && acc) |-> (col_r != s1_col_r), "line store read and write hit one column")
  `C2D_ASSERT_NEVER(a_fifo_overflow, clk, rst_n, mac_valid && (fifo_cnt_r == (FifoAw+1)'(FifoDepth)), "result queue overflow")
  `C2D_ASSERT(a_occ_covers, clk, rst_n, fifo_cnt_r <= occ_r, "queue holds more words than in flight")
  `C2D_ASSERT(a_emit_enters, clk, rst_n, (acc && emit) |=> (s1_valid_r && s1_emit_r), "result word lost after accept")

endmodule

FILE: sv/c2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module c2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/c2d_mac.sv
// Two-stage 3x3 multiply-accumulate, modulo 256.
`timescale 1ns / 1ps
module c2d_mac import c2d_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  c2d_meta_t in_meta,
  input  c2d_win_t  window,
  input  c2d_win_t  taps,
  output logic      out_valid,
  output c2d_meta_t out_meta,
  output logic [7:0] out_pixel
);

  c2d_win_t   prod_r, prod_nxt;
  logic       prod_valid_r;
  c2d_meta_t  prod_meta_r;
  logic [7:0] sum_r, sum_nxt;
  logic       sum_valid_r;
  c2d_meta_t  sum_meta_r;

  // Only the low byte of each product survives the wrap.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      prod_nxt[k] = 8'(window[k] * taps[k]);
    end
  end

  always_comb begin
    sum_nxt = 8'd0;
    for (int k = 0; k < 9; k++) begin
      sum_nxt = sum_nxt + prod_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      sum_valid_r  <= 1'b0;
    end else begin
      prod_valid_r <= in_valid;
      sum_valid_r  <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r      <= prod_nxt;
    prod_meta_r <= in_meta;
    sum_r       <= sum_nxt;
    sum_meta_r  <= prod_meta_r;
  end

  assign out_valid = sum_valid_r;
  assign out_meta  = sum_meta_r;
  assign out_pixel = sum_r;

endmodule
